@@ hw/rtl/psalu_pkg.sv @@
// ---------------------------------------------------------------------------
// PostScript integer ALU package
// Shared widths, operation codes and the beat records passed along the
// divider chain.
// ---------------------------------------------------------------------------
package psalu_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned WideW = 2 * DataW;
    localparam int unsigned OpW   = 3;

    typedef enum logic [OpW-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_IDIV = 3'd3,
        OP_MOD  = 3'd4,
        OP_ABS  = 3'd5,
        OP_NEG  = 3'd6,
        OP_IDENT = 3'd7
    } t_op;

    // Division working set: partial remainder, dividend bits shifting out
    // while quotient bits shift in, and the divisor magnitude.
    typedef struct packed {
        logic [DataW-1:0] rem;
        logic [DataW-1:0] dq;
        logic [DataW-1:0] dsr;
    } t_div;

    // Everything else a beat needs after the divider.
    typedef struct packed {
        t_op                     op;
        logic                    neg_q;
        logic                    neg_r;
        logic                    b_zero;
        logic                    b_m1;
        logic signed [WideW-1:0] other;
    } t_side;

endpackage

@@ hw/rtl/postscript_integer_alu_unit.sv @@
// ---------------------------------------------------------------------------
// PostScript integer ALU
// Stateless 32-bit integer unit; results outside the 32-bit range are
// returned as single-precision reals, rounded to nearest even.
// ---------------------------------------------------------------------------
// Usage: operation beats enter on the slave stream (tuser holds the
// operation code, tdata the two operands) and one result beat leaves on the
// master stream for every operation, in order.
// The unit is a fixed pipeline: one input stage holding the adder and the
// multiplier, a row of 32 divider cells that each settle one quotient bit,
// two result stages (range check with leading-one search, then rounding),
// and an output register. One operation is accepted every cycle while the
// skid register is free; the row of divider cells itself does not limit
// the rate.
// A skid register behind the output register lets the pipeline hand over
// one more result while the receiver stalls; with the skid register full
// the whole pipeline holds and o_s_tready drops, and it rises again in the
// cycle after the receiver takes a beat.
// Reset clears all valid bits; the unit then accepts beats at once.
// ---------------------------------------------------------------------------
module postscript_integer_alu_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [psalu_pkg::WideW-1:0]    i_s_tdata,   // operand_a, operand_b
    input  logic [psalu_pkg::OpW-1:0]      i_s_tuser,   // operation
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [psalu_pkg::WideW-1:0]    o_m_tdata,   // int_value, real_bits
    output logic [1:0]                     o_m_tuser    // is_real, error_code
);

    localparam int unsigned DataW = psalu_pkg::DataW;
    localparam int unsigned WideW = psalu_pkg::WideW;

    logic                    en;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [WideW-1:0] a64;
    logic signed [WideW-1:0] b64;
    logic signed [WideW-1:0] prod;
    psalu_pkg::t_op          op;
    psalu_pkg::t_side        n_side;
    psalu_pkg::t_div         n_div;

    logic                    r_f_valid;
    psalu_pkg::t_side        r_f_side;
    psalu_pkg::t_div         r_f_div;

    logic                    c_valid [0:DataW];
    psalu_pkg::t_div         c_div   [0:DataW];
    psalu_pkg::t_side        c_side  [0:DataW];

    logic                    p_valid;
    logic                    p_is_real;
    logic                    p_error;
    logic [DataW-1:0]        p_int;
    logic [DataW-1:0]        p_real;

    logic                    r_ov;
    logic [2*DataW+1:0]      r_out;
    logic                    r_sv;
    logic [2*DataW+1:0]      r_skid;
    logic [2*DataW+1:0]      p_beat;

    // The pipeline moves whenever the skid register is free.
    assign en         = !r_sv;
    assign o_s_tready = en;

    // Input stage: sums and the product are formed exactly at double width.
    always_comb begin
        a    = i_s_tdata[DataW-1:0];
        b    = i_s_tdata[2*DataW-1:DataW];
        op   = psalu_pkg::t_op'(i_s_tuser);
        a64  = WideW'(a);
        b64  = WideW'(b);
        prod = a * b;
        unique case (op)
            psalu_pkg::OP_ADD: n_side.other = a64 + b64;
            psalu_pkg::OP_SUB: n_side.other = a64 - b64;
            psalu_pkg::OP_MUL: n_side.other = prod;
            psalu_pkg::OP_ABS: n_side.other = a[DataW-1] ? -a64 : a64;
            psalu_pkg::OP_NEG: n_side.other = -a64;
            default:           n_side.other = a64;
        endcase
        n_side.op     = op;
        n_side.neg_q  = a[DataW-1] ^ b[DataW-1];
        n_side.neg_r  = a[DataW-1];
        n_side.b_zero = (b == '0);
        n_side.b_m1   = (b == '1);
        n_div.rem     = '0;
        n_div.dq      = a[DataW-1] ? DataW'(-a) : DataW'(a);
        n_div.dsr     = b[DataW-1] ? DataW'(-b) : DataW'(b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_side <= n_side;
            r_f_div  <= n_div;
        end
    end

    assign c_valid[0] = r_f_valid;
    assign c_div[0]   = r_f_div;
    assign c_side[0]  = r_f_side;

    // Row of divider cells, one quotient bit per cell, most significant first.
    for (genvar k = 0; k < DataW; k++) begin : g_cell
        psalu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[k]),
            .i_div   (c_div[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .o_div   (c_div[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    psalu_post u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (c_valid[DataW]),
        .i_div     (c_div[DataW]),
        .i_side    (c_side[DataW]),
        .o_valid   (p_valid),
        .o_is_real (p_is_real),
        .o_error   (p_error),
        .o_int     (p_int),
        .o_real    (p_real)
    );

    assign p_beat = {p_error, p_is_real, p_real, p_int};

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_m_tready) begin
                r_sv <= 1'b0;
            end
        end else if (p_valid) begin
            if (r_ov && !i_m_tready) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (i_m_tready) begin
                r_out <= r_skid;
            end
        end else if (p_valid) begin
            if (r_ov && !i_m_tready) begin
                r_skid <= p_beat;
            end else begin
                r_out <= p_beat;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out[2*DataW-1:0];
    assign o_m_tuser  = r_out[2*DataW+1:2*DataW];

    a_skid_needs_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid register full while output empty");

    a_skid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv && !i_m_tready |=> r_sv && r_ov) else $error("stalled skid beat lost");

    a_err_not_real : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(o_m_tuser[0] && o_m_tuser[1])) else $error("error beat marked real");

    a_real_int_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && o_m_tuser[0] |-> o_m_tdata[DataW-1:0] == '0)
        else $error("real result with nonzero integer field");

endmodule

@@ hw/rtl/psalu_cell.sv @@
// ---------------------------------------------------------------------------
// Divider cell
// One restoring division step: produces one quotient bit and hands the
// working set and the side record to the next cell.
// ---------------------------------------------------------------------------
module psalu_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  psalu_pkg::t_div  i_div,
    input  psalu_pkg::t_side i_side,
    output logic             o_valid,
    output psalu_pkg::t_div  o_div,
    output psalu_pkg::t_side o_side
);

    logic [psalu_pkg::DataW-1:0] trial;
    logic                        ge;
    psalu_pkg::t_div             n_div;
    logic                        r_valid;
    psalu_pkg::t_div             r_div;
    psalu_pkg::t_side            r_side;

    // For a nonzero divisor the remainder stays below it, so the shifted trial fits.
    always_comb begin
        trial       = {i_div.rem[psalu_pkg::DataW-2:0], i_div.dq[psalu_pkg::DataW-1]};
        ge          = (trial >= i_div.dsr);
        n_div.rem   = ge ? (trial - i_div.dsr) : trial;
        n_div.dq    = {i_div.dq[psalu_pkg::DataW-2:0], ge};
        n_div.dsr   = i_div.dsr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

@@ hw/rtl/psalu_post.sv @@
// ---------------------------------------------------------------------------
// Result former
// Applies signs to quotient and remainder, selects the result, detects
// leaving the 32-bit range and converts such values to single precision.
// ---------------------------------------------------------------------------
module psalu_post (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  psalu_pkg::t_div             i_div,
    input  psalu_pkg::t_side            i_side,
    output logic                        o_valid,
    output logic                        o_is_real,
    output logic                        o_error,
    output logic [psalu_pkg::DataW-1:0] o_int,
    output logic [psalu_pkg::DataW-1:0] o_real
);

    localparam int unsigned WideW = psalu_pkg::WideW;
    localparam int unsigned DataW = psalu_pkg::DataW;
    localparam int unsigned PosW  = $clog2(WideW);

    logic signed [WideW-1:0] qv;
    logic signed [WideW-1:0] rv;
    logic signed [WideW-1:0] res;
    logic                    err;
    logic                    ovf;
    logic [WideW-1:0]        mag;
    logic [PosW-1:0]         msb;

    logic                    r_a_valid;
    logic                    r_a_err;
    logic                    r_a_ovf;
    logic                    r_a_neg;
    logic [WideW-1:0]        r_a_mag;
    logic [PosW-1:0]         r_a_msb;
    logic [DataW-1:0]        r_a_int;

    logic [PosW-1:0]         sh;
    logic [WideW-1:0]        shifted;
    logic [WideW-1:0]        mask;
    logic [WideW-1:0]        half;
    logic [WideW-1:0]        rem;
    logic                    rnd;
    logic [24:0]             mant;
    logic [7:0]              expo;
    logic [DataW-1:0]        bits;

    logic                    r_valid;
    logic                    r_is_real;
    logic                    r_error;
    logic [DataW-1:0]        r_int;
    logic [DataW-1:0]        r_real;

    always_comb begin
        qv  = {{DataW{1'b0}}, i_div.dq};
        rv  = {{DataW{1'b0}}, i_div.rem};
        res = i_side.other;
        err = 1'b0;
        unique case (i_side.op)
            psalu_pkg::OP_IDIV: begin
                res = i_side.neg_q ? -qv : qv;
                err = i_side.b_zero;
            end
            psalu_pkg::OP_MOD: begin
                res = i_side.b_m1 ? '0 : (i_side.neg_r ? -rv : rv);
                err = i_side.b_zero;
            end
            default: ;
        endcase
        ovf = !err && !((&res[WideW-1:DataW-1]) || !(|res[WideW-1:DataW-1]));
        mag = res[WideW-1] ? WideW'(-res) : WideW'(res);
        msb = '0;
        for (int i = 0; i < WideW; i++) begin
            if (mag[i]) msb = PosW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_valid   <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_err <= err;
            r_a_ovf <= ovf;
            r_a_neg <= res[WideW-1];
            r_a_mag <= mag;
            r_a_msb <= msb;
            r_a_int <= res[DataW-1:0];
        end
    end

    // Out-of-range values have their leading one at bit 31 or above, so the
    // mantissa is always taken by a right shift with rounding.
    always_comb begin
        sh      = r_a_msb - PosW'(23);
        shifted = r_a_mag >> sh;
        mask    = (WideW'(1) << sh) - WideW'(1);
        half    = WideW'(1) << (sh - PosW'(1));
        rem     = r_a_mag & mask;
        rnd     = (rem > half) || ((rem == half) && shifted[0]);
        mant    = {1'b0, shifted[23:0]} + {24'd0, rnd};
        expo    = 8'(r_a_msb) + 8'd127 + {7'd0, mant[24]};
        bits    = {r_a_neg, expo, (mant[24] ? mant[23:1] : mant[22:0])};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_is_real <= r_a_ovf;
            r_error   <= r_a_err;
            r_int     <= (r_a_ovf || r_a_err) ? '0 : r_a_int;
            r_real    <= r_a_ovf ? bits : '0;
        end
    end

    assign o_valid   = r_valid;
    assign o_is_real = r_is_real;
    assign o_error   = r_error;
    assign o_int     = r_int;
    assign o_real    = r_real;

endmodule
